// ----- rtl/core/trwa_pkg.sv -----
// Shared types, constants and codes for the timed ring window average block.
package trwa_pkg;

   localparam int RING_DEPTH_DEFAULT = 12;

   localparam int PPM_W    = 16;
   localparam int TEMP_W   = 15;
   localparam int RH_W     = 14;
   localparam int STAMP_W  = 48;
   localparam int WINDOW_W = 24;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd5000;

   localparam logic MODE_PUSH  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Divider lanes, all sharing one divisor.
   localparam int LANE_COUNT = 3;
   localparam int LANE_PPM   = 0;
   localparam int LANE_TEMP  = 1;
   localparam int LANE_RH    = 2;

   typedef struct packed {
      logic        [PPM_W-1:0]   ppm;
      logic signed [TEMP_W-1:0]  temp_centi;
      logic        [RH_W-1:0]    rh_centi;
      logic        [STAMP_W-1:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_START,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

endpackage

// ----- rtl/core/trwa_if.sv -----
// Request and response channel interfaces.
interface trwa_req_if
   import trwa_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic        [PPM_W-1:0]    ppm;
   logic signed [TEMP_W-1:0]   temp_centi;
   logic        [RH_W-1:0]     rh_centi;
   logic        [STAMP_W-1:0]  time_ms;

   modport source (output valid, mode, ppm, temp_centi, rh_centi, time_ms, input ready);
   modport sink   (input valid, mode, ppm, temp_centi, rh_centi, time_ms, output ready);
endinterface

interface trwa_rsp_if
   import trwa_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic        [PPM_W-1:0]    avg_ppm;
   logic signed [TEMP_W-1:0]   avg_temp_centi;
   logic        [RH_W-1:0]     avg_rh_centi;

   modport source (output valid, found, avg_ppm, avg_temp_centi, avg_rh_centi, input ready);
   modport sink   (input valid, found, avg_ppm, avg_temp_centi, avg_rh_centi, output ready);
endinterface

// ----- rtl/core/trwa_divider.sv -----
// Restoring divider, one quotient bit per cycle, several dividends over one divisor.
module trwa_divider
   import trwa_pkg::*;
#(
   parameter int DIVIDEND_W = 20,
   parameter int DIVISOR_W  = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [LANE_COUNT-1:0][DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]                  divisor,
   output logic                                  done,
   output logic [LANE_COUNT-1:0][DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [STEP_W-1:0]                     step_ff, step_in;
   logic [DIVISOR_W-1:0]                  divisor_ff, divisor_in;
   logic [LANE_COUNT-1:0][DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [LANE_COUNT-1:0][DIVIDEND_W-1:0] quot_ff, quot_in;

   always_comb begin
      logic [DIVISOR_W:0] partial;
      logic [DIVISOR_W:0] diff;
      logic               ge;

      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      partial    = '0;
      diff       = '0;
      ge         = 1'b0;

      if (start) begin
         busy_in    = 1'b1;
         step_in    = STEP_W'(DIVIDEND_W);
         divisor_in = divisor;
         rem_in     = '0;
         quot_in    = dividend;
      end else if (busy_ff) begin
         for (int lane = 0; lane < LANE_COUNT; lane++) begin
            partial = {rem_ff[lane], quot_ff[lane][DIVIDEND_W-1]};
            diff    = partial - {1'b0, divisor_ff};
            ge      = (partial >= {1'b0, divisor_ff});
            rem_in[lane]  = ge ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
            quot_in[lane] = {quot_ff[lane][DIVIDEND_W-2:0], ge};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ----- rtl/core/timed_ring_window_average.sv -----
// Time-windowed moving average over a ring of timestamped samples, one item at a time.
// Push: the ring is written at the accepting edge; no response.
// Query: checks one ring entry per cycle, newest first, stopping at the first stale one, then
//   divides the three sums by the count of entries taken; the divide is skipped when none was
//   taken, and an empty ring goes straight to the response; a held response stalls.
// Reset (synchronous, active high) empties the ring and restores window_ff to 5000.
module timed_ring_window_average
   import trwa_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   trwa_req_if.sink            req,
   trwa_rsp_if.source          rsp,
   input  logic                csr_wr_en,
   input  logic [WINDOW_W-1:0] csr_wr_data
);

   localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int PSUM_W = PPM_W + CNT_W;
   localparam int TSUM_W = TEMP_W + CNT_W;
   localparam int RSUM_W = RH_W + CNT_W;
   localparam int DIV_W  = PPM_W + CNT_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          wptr_ff, wptr_in;
   logic [CNT_W-1:0]          fill_ff, fill_in;
   logic [WINDOW_W-1:0]       window_ff;
   logic [STAMP_W-1:0]        now_ff, now_in;
   logic [IDX_W-1:0]          issue_idx_ff, issue_idx_in;
   logic [CNT_W-1:0]          issue_left_ff, issue_left_in;
   logic [CNT_W-1:0]          check_left_ff, check_left_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [PSUM_W-1:0]         sum_ppm_ff, sum_ppm_in;
   logic signed [TSUM_W-1:0]  sum_temp_ff, sum_temp_in;
   logic [RSUM_W-1:0]         sum_rh_ff, sum_rh_in;
   logic                      rd_vld_ff;
   entry_type                 rd_data_ff;
   logic                      rd_en;
   logic                      push_we;
   logic                      take;
   logic                      rsp_load;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      found_ff;
   logic [PPM_W-1:0]          avg_ppm_ff;
   logic signed [TEMP_W-1:0]  avg_temp_ff;
   logic [RH_W-1:0]           avg_rh_ff;

   entry_type ring_mem [RING_DEPTH];

   // Divider hookup
   logic                                  div_start;
   logic                                  div_done;
   logic [LANE_COUNT-1:0][DIV_W-1:0]      div_dividend;
   logic [LANE_COUNT-1:0][DIV_W-1:0]      div_quotient;
   logic signed [DIV_W-1:0]               temp_ext;
   logic                                  temp_neg;
   logic [DIV_W-1:0]                      temp_quot;

   assign temp_neg = sum_temp_ff[TSUM_W-1];
   assign temp_ext = DIV_W'(sum_temp_ff);

   always_comb begin
      div_dividend            = '0;
      div_dividend[LANE_PPM]  = DIV_W'(sum_ppm_ff);
      div_dividend[LANE_TEMP] = temp_neg ? -temp_ext : temp_ext;
      div_dividend[LANE_RH]   = DIV_W'(sum_rh_ff);
   end

   trwa_divider #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // An entry is in the window when stamp + window >= now; no underflow this way.
   assign take = ({1'b0, rd_data_ff.stamp} + {{(STAMP_W + 1 - WINDOW_W){1'b0}}, window_ff})
                 >= {1'b0, now_ff};

   assign rd_en   = (state_ff == ST_WALK) && (issue_left_ff != '0);
   assign push_we = (state_ff == ST_IDLE) && req.valid && (req.mode == MODE_PUSH);

   always_comb begin
      state_in      = state_ff;
      wptr_in       = wptr_ff;
      fill_in       = fill_ff;
      now_in        = now_ff;
      issue_idx_in  = issue_idx_ff;
      issue_left_in = issue_left_ff;
      check_left_in = check_left_ff;
      count_in      = count_ff;
      sum_ppm_in    = sum_ppm_ff;
      sum_temp_in   = sum_temp_ff;
      sum_rh_in     = sum_rh_ff;
      div_start     = 1'b0;
      rsp_load      = 1'b0;
      req.ready     = 1'b0;

      // Keep issuing reads toward older entries; surplus reads are dropped.
      if (rd_en) begin
         issue_idx_in  = (issue_idx_ff == '0) ? LAST_IDX : issue_idx_ff - 1'b1;
         issue_left_in = issue_left_ff - 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.mode == MODE_PUSH) begin
                  wptr_in = (wptr_ff == LAST_IDX) ? '0 : wptr_ff + 1'b1;
                  if (fill_ff < CNT_W'(RING_DEPTH)) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end else begin
                  now_in        = req.time_ms;
                  count_in      = '0;
                  sum_ppm_in    = '0;
                  sum_temp_in   = '0;
                  sum_rh_in     = '0;
                  issue_idx_in  = (wptr_ff == '0) ? LAST_IDX : wptr_ff - 1'b1;
                  issue_left_in = fill_ff;
                  check_left_in = fill_ff;
                  state_in      = (fill_ff == '0) ? ST_HOLD : ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (rd_vld_ff) begin
               check_left_in = check_left_ff - 1'b1;
               if (take) begin
                  count_in    = count_ff + 1'b1;
                  sum_ppm_in  = sum_ppm_ff + PSUM_W'(rd_data_ff.ppm);
                  sum_temp_in = sum_temp_ff + TSUM_W'(rd_data_ff.temp_centi);
                  sum_rh_in   = sum_rh_ff + RSUM_W'(rd_data_ff.rh_centi);
               end
               if (!take || check_left_ff == CNT_W'(1)) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (count_ff == '0) begin
               state_in = ST_HOLD;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // Wait for the output register to free up.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   assign temp_quot    = temp_neg ? -div_quotient[LANE_TEMP] : div_quotient[LANE_TEMP];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wptr_ff       <= '0;
         fill_ff       <= '0;
         window_ff     <= WINDOW_RESET;
         issue_left_ff <= '0;
         check_left_ff <= '0;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wptr_ff       <= wptr_in;
         fill_ff       <= fill_in;
         issue_left_ff <= issue_left_in;
         check_left_ff <= check_left_in;
         count_ff      <= count_in;
         rd_vld_ff     <= rd_en;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      issue_idx_ff <= issue_idx_in;
      sum_ppm_ff   <= sum_ppm_in;
      sum_temp_ff  <= sum_temp_in;
      sum_rh_ff    <= sum_rh_in;
      if (rsp_load) begin
         found_ff    <= (count_ff != '0);
         avg_ppm_ff  <= (count_ff != '0) ? div_quotient[LANE_PPM][PPM_W-1:0] : '0;
         avg_temp_ff <= (count_ff != '0) ? signed'(temp_quot[TEMP_W-1:0]) : '0;
         avg_rh_ff   <= (count_ff != '0) ? div_quotient[LANE_RH][RH_W-1:0] : '0;
      end
   end

   // Ring memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (push_we) begin
         ring_mem[wptr_ff] <= '{ppm:        req.ppm,
                                temp_centi: req.temp_centi,
                                rh_centi:   req.rh_centi,
                                stamp:      req.time_ms};
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[issue_idx_ff];
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.found          = found_ff;
   assign rsp.avg_ppm        = avg_ppm_ff;
   assign rsp.avg_temp_centi = avg_temp_ff;
   assign rsp.avg_rh_centi   = avg_rh_ff;

   a_fill_bounded : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(RING_DEPTH))
      else $error("fill count beyond ring depth");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= fill_ff)
      else $error("taken entries exceed filled entries");

   a_query_starts_walk : assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.mode == MODE_QUERY) |=>
         (state_ff == ST_WALK || state_ff == ST_HOLD))
      else $error("query transfer did not start a walk");

   a_done_in_divide : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide phase");

endmodule

// ----- test/trwa_window_checker.sv -----
// Channel monitor that predicts each query's windowed averages and checks every response.
module trwa_window_checker
   import trwa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   trwa_req_if                 req_mon,
   trwa_rsp_if                 rsp_mon,
   input  logic                csr_wr_en,
   input  logic [WINDOW_W-1:0] csr_wr_data,
   output int                  mismatch_count,
   output int                  averages_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = RING_DEPTH_DEFAULT;

   typedef struct packed {
      logic                      found;
      logic        [PPM_W-1:0]   avg_ppm;
      logic signed [TEMP_W-1:0]  avg_temp_centi;
      logic        [RH_W-1:0]    avg_rh_centi;
   } window_average_type;

   logic        [PPM_W-1:0]   ring_ppm   [DEPTH];
   logic signed [TEMP_W-1:0]  ring_temp  [DEPTH];
   logic        [RH_W-1:0]    ring_rh    [DEPTH];
   logic        [STAMP_W-1:0] ring_stamp [DEPTH];
   int                        write_slot = 0;
   int                        fill_level = 0;
   logic        [WINDOW_W-1:0] window_len = WINDOW_RESET;
   window_average_type        owed_averages [$];
   int                        failures = 0;
   int                        owed_now = 0;

   assign mismatch_count = failures;
   assign averages_owed  = owed_now;

   // Walk newest to oldest, stop at the first sample that fell out of the window.
   function automatic window_average_type average_window(input logic [STAMP_W-1:0] now);
      window_average_type avg;
      longint unsigned   ppm_sum;
      longint unsigned   rh_sum;
      longint            temp_sum;
      longint            taken;
      longint unsigned   reach;
      int                slot;
      avg      = '0;
      ppm_sum  = 0;
      rh_sum   = 0;
      temp_sum = 0;
      taken    = 0;
      for (int i = 0; i < fill_level; i++) begin
         slot  = (write_slot + DEPTH - 1 - i) % DEPTH;
         reach = 64'(ring_stamp[slot]) + 64'(window_len);
         if (reach < 64'(now)) break;
         ppm_sum  += 64'(ring_ppm[slot]);
         rh_sum   += 64'(ring_rh[slot]);
         temp_sum += longint'(ring_temp[slot]);
         taken++;
      end
      if (taken > 0) begin
         avg.found          = 1'b1;
         avg.avg_ppm        = PPM_W'(ppm_sum / 64'(taken));
         avg.avg_temp_centi = TEMP_W'(temp_sum / taken);
         avg.avg_rh_centi   = RH_W'(rh_sum / 64'(taken));
      end
      return avg;
   endfunction

   always @(posedge clock) begin
      window_average_type want;
      int                 errs;
      if (reset) begin
         write_slot = 0;
         fill_level = 0;
         window_len = WINDOW_RESET;
         owed_averages.delete();
         owed_now <= 0;
      end else begin
         errs = 0;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_averages.size() == 0) begin
               $error("response transfer with no query pending: found=%0d avg_ppm=%0d",
                      rsp_mon.found, rsp_mon.avg_ppm);
               errs++;
            end else begin
               want = owed_averages.pop_front();
               if (rsp_mon.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_mon.found);
                  errs++;
               end
               if (rsp_mon.avg_ppm !== want.avg_ppm) begin
                  $error("avg_ppm: expected %0d, got %0d", want.avg_ppm, rsp_mon.avg_ppm);
                  errs++;
               end
               if (rsp_mon.avg_temp_centi !== want.avg_temp_centi) begin
                  $error("avg_temp_centi: expected %0d, got %0d",
                         want.avg_temp_centi, rsp_mon.avg_temp_centi);
                  errs++;
               end
               if (rsp_mon.avg_rh_centi !== want.avg_rh_centi) begin
                  $error("avg_rh_centi: expected %0d, got %0d",
                         want.avg_rh_centi, rsp_mon.avg_rh_centi);
                  errs++;
               end
            end
         end
         if (csr_wr_en) begin
            window_len = csr_wr_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.mode == MODE_QUERY) begin
               owed_averages.push_back(average_window(req_mon.time_ms));
            end else begin
               // Overwrite the oldest slot once the ring is full.
               ring_ppm[write_slot]   = req_mon.ppm;
               ring_temp[write_slot]  = req_mon.temp_centi;
               ring_rh[write_slot]    = req_mon.rh_centi;
               ring_stamp[write_slot] = req_mon.time_ms;
               write_slot = (write_slot + 1) % DEPTH;
               if (fill_level < DEPTH) fill_level++;
            end
         end
         failures <= failures + errs;
         owed_now <= owed_averages.size();
      end
   end

endmodule

// ----- test/tb.sv -----
// Stimulus and verdict for the timed ring window average block.
module tb;
   import trwa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned STAMP_TOP    = 64'h0000_FFFF_FFFF_FFFF;
   localparam int              DRAIN_CYCLES = 48;
   localparam int              HOLD_CYCLES  = 300;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [WINDOW_W-1:0] csr_wr_data;
   int                  mismatch_total;
   int                  averages_owed;
   bit                  in_gaps = 1'b1;
   bit                  out_gaps = 1'b1;
   bit                  hold_request = 1'b0;
   longint unsigned     now_ms = 0;
   int unsigned         window_now = 5000;

   trwa_req_if req_ch ();
   trwa_rsp_if rsp_ch ();

   timed_ring_window_average i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   trwa_window_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_total),
      .averages_owed  (averages_owed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Response side: random back-pressure, or a long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(out_gaps && $urandom_range(99) < 19);
         end
      end
   end

   task automatic send_item(input logic mode, input int unsigned ppm, input int temp,
                            input int unsigned rh, input longint unsigned stamp);
      if (in_gaps && $urandom_range(99) < 19) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= mode;
      req_ch.ppm        <= PPM_W'(ppm);
      req_ch.temp_centi <= TEMP_W'(temp);
      req_ch.rh_centi   <= RH_W'(rh);
      req_ch.time_ms    <= STAMP_W'(stamp);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drop valid, wait for every owed average, then let the block go quiet.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (averages_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input int unsigned span);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= WINDOW_W'(span);
      window_now  = span;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int items);
      int              roll;
      int              temp_draw;
      int unsigned     ppm_draw;
      longint unsigned stamp;
      for (int k = 0; k < items; k++) begin
         roll = $urandom_range(99);
         if (roll < 55) begin
            // Regular sample roughly once a second.
            now_ms   += $urandom_range(1800, 200);
            temp_draw = int'($urandom_range(16500)) - 4000;
            ppm_draw  = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                 : $urandom_range(5000, 400);
            send_item(MODE_PUSH, ppm_draw, temp_draw, $urandom_range(10000), now_ms);
         end else if (roll < 90) begin
            case ($urandom_range(3))
               0:       stamp = now_ms;
               1:       stamp = now_ms + $urandom_range(12000);
               2:       stamp = now_ms - $urandom_range(3000);
               default: stamp = now_ms + window_now + $urandom_range(1);
            endcase
            send_item(MODE_QUERY, $urandom(), int'($urandom()), $urandom(), stamp);
         end else begin
            send_item(1'($urandom_range(1)), $urandom(), int'($urandom()), $urandom(),
                      {$urandom(), $urandom()});
         end
         if ($urandom_range(149) == 0) settle();
      end
   endtask

   initial begin
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.mode       <= MODE_PUSH;
      req_ch.ppm        <= '0;
      req_ch.temp_centi <= '0;
      req_ch.rh_centi   <= '0;
      req_ch.time_ms    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset window.
      send_item(MODE_QUERY, 0, 0, 0, 0);
      send_item(MODE_PUSH, 0, -4000, 0, 0);
      send_item(MODE_PUSH, 65535, 12500, 10000, 1000);
      send_item(MODE_PUSH, 65535, -16384, 16383, 2000);
      send_item(MODE_PUSH, 0, 16383, 0, 3000);
      send_item(MODE_QUERY, 0, 0, 0, 4000);
      send_item(MODE_QUERY, 0, 0, 0, 8000);
      send_item(MODE_QUERY, 0, 0, 0, STAMP_TOP);
      send_item(MODE_PUSH, 1, -1, 1, STAMP_TOP);
      send_item(MODE_QUERY, 0, 0, 0, STAMP_TOP);
      send_item(MODE_QUERY, 0, 0, 0, 100);
      for (int k = 0; k < 8; k++) begin
         send_item(MODE_PUSH, 7 * k + 3, -(2 * k + 1), 3 * k + 2, 10000 + 500 * k);
      end
      send_item(MODE_QUERY, 0, 0, 0, 16000);

      now_ms = 1_000_000;
      run_random(200);
      write_window(0);
      run_random(150);
      write_window(24'hFF_FFFF);
      run_random(150);

      in_gaps  = 1'b0;
      out_gaps = 1'b0;
      write_window(1000);
      run_random(200);

      in_gaps  = 1'b1;
      out_gaps = 1'b1;
      write_window(3000);
      hold_request = 1'b1;
      run_random(40);
      run_random(160);
      write_window($urandom_range(20000, 500));
      run_random(200);
      write_window(5000);
      run_random(100);

      settle();
      if (mismatch_total == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
